// File: hw/rtl/bearing_angle_degrees_defines.svh
// Assertion macros shared by the bearing block.
`ifndef BEARING_ANGLE_DEGREES_DEFINES_SVH
`define BEARING_ANGLE_DEGREES_DEFINES_SVH

// Check a property on clk_i, muted while reset is held.
`define BRG_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bearing check failed");

// Check a property on clk_i, including the reset interval.
`define BRG_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("bearing check failed during reset");

`endif

// File: hw/rtl/brg_pkg.sv
package brg_pkg;

  // CORDIC datapath: magnitudes are scaled to MagTopBits bits, the rest is headroom
  localparam int unsigned MagTopBits = 58;
  localparam int unsigned DatW       = 62;
  localparam int unsigned ZW         = 25;
  localparam int unsigned TableLen   = 24;

  localparam int unsigned Deg90Q16  = 5898240;
  localparam int unsigned Deg90Q8   = 23040;
  localparam int unsigned Deg180Q8  = 46080;
  localparam int unsigned Deg360Q8  = 92160;
  localparam int unsigned RoundHalf = 128;

  typedef enum logic [1:0] {
    QuadFirst  = 2'd0,
    QuadSecond = 2'd1,
    QuadThird  = 2'd2,
    QuadFourth = 2'd3
  } quad_e;

  typedef struct packed {
    logic signed [DatW-1:0] x;
    logic signed [DatW-1:0] y;
    logic signed [ZW-1:0]   z;
    quad_e                  quad;
    logic                   force90;
  } cordic_t;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic [ZW-1:0] atan_q16(input logic [4:0] idx);
    logic [ZW-1:0] v;
    case (idx)
      5'd0:    v = ZW'(2949120);
      5'd1:    v = ZW'(1740967);
      5'd2:    v = ZW'(919879);
      5'd3:    v = ZW'(466945);
      5'd4:    v = ZW'(234379);
      5'd5:    v = ZW'(117304);
      5'd6:    v = ZW'(58666);
      5'd7:    v = ZW'(29335);
      5'd8:    v = ZW'(14668);
      5'd9:    v = ZW'(7334);
      5'd10:   v = ZW'(3667);
      5'd11:   v = ZW'(1833);
      5'd12:   v = ZW'(917);
      5'd13:   v = ZW'(458);
      5'd14:   v = ZW'(229);
      5'd15:   v = ZW'(115);
      5'd16:   v = ZW'(57);
      5'd17:   v = ZW'(29);
      5'd18:   v = ZW'(14);
      5'd19:   v = ZW'(7);
      5'd20:   v = ZW'(4);
      5'd21:   v = ZW'(2);
      5'd22:   v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/brg_prep.sv
module brg_prep #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [COORD_BITS-1:0] cur_x_i,
  input  logic signed [COORD_BITS-1:0] cur_y_i,
  input  logic signed [COORD_BITS-1:0] goal_x_i,
  input  logic signed [COORD_BITS-1:0] goal_y_i,
  output logic                         valid_o,
  output brg_pkg::cordic_t             data_o
);

  localparam int unsigned Guard = brg_pkg::MagTopBits - COORD_BITS;
  localparam int unsigned Pad   = brg_pkg::DatW - brg_pkg::MagTopBits;

  logic signed [COORD_BITS:0] dx_d, dy_d, dx_q, dy_q;
  logic                       v1_q;
  brg_pkg::quad_e             quad_d, quad_q;
  logic [COORD_BITS:0]        neg_x, neg_y;
  logic [COORD_BITS-1:0]      mag_x, mag_y;
  brg_pkg::cordic_t           data_d, data_q;
  logic                       v2_q;

  // Take signed differences and pick the quarter from their signs
  always_comb begin
    dx_d = {goal_x_i[COORD_BITS-1], goal_x_i} - {cur_x_i[COORD_BITS-1], cur_x_i};
    dy_d = {goal_y_i[COORD_BITS-1], goal_y_i} - {cur_y_i[COORD_BITS-1], cur_y_i};
    if (dy_d[COORD_BITS]) begin
      quad_d = dx_d[COORD_BITS] ? brg_pkg::QuadSecond : brg_pkg::QuadFirst;
    end else begin
      quad_d = dx_d[COORD_BITS] ? brg_pkg::QuadThird : brg_pkg::QuadFourth;
    end
  end

  // Form magnitudes and scale them into the CORDIC word
  always_comb begin
    neg_x = -dx_q;
    neg_y = -dy_q;
    mag_x = dx_q[COORD_BITS] ? neg_x[COORD_BITS-1:0] : dx_q[COORD_BITS-1:0];
    mag_y = dy_q[COORD_BITS] ? neg_y[COORD_BITS-1:0] : dy_q[COORD_BITS-1:0];
    data_d.x       = $signed({{Pad{1'b0}}, mag_x, {Guard{1'b0}}});
    data_d.y       = $signed({{Pad{1'b0}}, mag_y, {Guard{1'b0}}});
    data_d.z       = '0;
    data_d.quad    = quad_q;
    data_d.force90 = (mag_x == '0) && (mag_y != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      quad_q <= quad_d;
      data_q <= data_d;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = data_q;

endmodule

// File: hw/rtl/brg_cordic_stage.sv
module brg_cordic_stage #(
  parameter int unsigned STAGE = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  brg_pkg::cordic_t data_i,
  output logic             valid_o,
  output brg_pkg::cordic_t data_o
);

  logic signed [brg_pkg::DatW-1:0] xs, ys;
  logic signed [brg_pkg::ZW-1:0]   step;
  brg_pkg::cordic_t                data_d, data_q;
  logic                            valid_q;

  // Rotate toward y = 0; floor shifts, no move once y is exactly zero
  always_comb begin
    xs     = data_i.x >>> STAGE;
    ys     = data_i.y >>> STAGE;
    step   = $signed(brg_pkg::atan_q16(5'(STAGE)));
    data_d = data_i;
    if (data_i.y != '0) begin
      if (!data_i.y[brg_pkg::DatW-1]) begin
        data_d.x = data_i.x + ys;
        data_d.y = data_i.y - xs;
        data_d.z = data_i.z + step;
      end else begin
        data_d.x = data_i.x - ys;
        data_d.y = data_i.y + xs;
        data_d.z = data_i.z - step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hw/rtl/brg_fold.sv
module brg_fold (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  brg_pkg::cordic_t data_i,
  output logic             valid_o,
  output logic [16:0]      yaw_deg_o,
  output logic [1:0]       quadrant_o
);

  logic [22:0]    z_clamp;
  logic [23:0]    z_round;
  logic [16:0]    ang;
  logic [16:0]    yaw_d, yaw_q;
  logic [1:0]     quad_q;
  logic           valid_q;

  // Clamp to 0..90 degrees, round to 8 fraction bits, fold by quarter
  always_comb begin
    if (data_i.z[brg_pkg::ZW-1]) begin
      z_clamp = '0;
    end else if (data_i.z > $signed(brg_pkg::ZW'(brg_pkg::Deg90Q16))) begin
      z_clamp = 23'(brg_pkg::Deg90Q16);
    end else begin
      z_clamp = data_i.z[22:0];
    end
    z_round = {1'b0, z_clamp} + 24'(brg_pkg::RoundHalf);
    if (data_i.force90) begin
      ang = 17'(brg_pkg::Deg90Q8);
    end else begin
      ang = {1'b0, z_round[23:8]};
    end
    case (data_i.quad)
      brg_pkg::QuadFirst:  yaw_d = ang;
      brg_pkg::QuadSecond: yaw_d = 17'(brg_pkg::Deg180Q8) - ang;
      brg_pkg::QuadThird:  yaw_d = 17'(brg_pkg::Deg180Q8) + ang;
      default:             yaw_d = 17'(brg_pkg::Deg360Q8) - ang;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yaw_q  <= yaw_d;
      quad_q <= data_i.quad;
    end
  end

  assign valid_o    = valid_q;
  assign yaw_deg_o  = yaw_q;
  assign quadrant_o = quad_q;

endmodule

// File: hw/rtl/bearing_angle_degrees.sv
// Bearing from a current grid position to a goal position in degrees, y growing
// downward, as unsigned degrees with 8 fraction bits (0..360) plus the goal's
// quarter. One word is accepted every clock cycle while the input stall is low;
// each result passes through registers that form the differences, then the
// magnitudes, then one per CORDIC iteration, then one that clamps, rounds and
// folds. An output stall while a finished word waits at the output freezes the
// whole pipeline and is passed straight back as the input stall. An equal-y goal
// to the right, or an equal position, reads 360 degrees; an equal-y goal to the
// left reads 180.
`include "bearing_angle_degrees_defines.svh"

module bearing_angle_degrees #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned COORD_BITS    = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] cur_x_i,
  input  logic signed [COORD_BITS-1:0] cur_y_i,
  input  logic signed [COORD_BITS-1:0] goal_x_i,
  input  logic signed [COORD_BITS-1:0] goal_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [16:0]                  yaw_deg_o,
  output logic [1:0]                   quadrant_o
);

  localparam int unsigned NStages =
    (CORDIC_STAGES > brg_pkg::TableLen) ? brg_pkg::TableLen : CORDIC_STAGES;

  logic             en;
  logic             st_valid [NStages+1];
  brg_pkg::cordic_t st_data  [NStages+1];

  // Advance every stage unless a finished word is held at the output
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  brg_prep #(
    .COORD_BITS(COORD_BITS)
  ) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .cur_x_i  (cur_x_i),
    .cur_y_i  (cur_y_i),
    .goal_x_i (goal_x_i),
    .goal_y_i (goal_y_i),
    .valid_o  (st_valid[0]),
    .data_o   (st_data[0])
  );

  // One CORDIC iteration per register stage
  for (genvar i = 0; i < NStages; i++) begin : g_stage
    brg_cordic_stage #(
      .STAGE(i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (st_valid[i]),
      .data_i  (st_data[i]),
      .valid_o (st_valid[i+1]),
      .data_o  (st_data[i+1])
    );
  end

  brg_fold u_fold (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (st_valid[NStages]),
    .data_i     (st_data[NStages]),
    .valid_o    (out_valid_o),
    .yaw_deg_o  (yaw_deg_o),
    .quadrant_o (quadrant_o)
  );

  // Folded angle must sit inside the range of its quarter
  `BRG_ASSERT(a_first_range,
    out_valid_o && (quadrant_o == brg_pkg::QuadFirst) |-> yaw_deg_o <= 17'd23040)
  `BRG_ASSERT(a_second_range,
    out_valid_o && (quadrant_o == brg_pkg::QuadSecond) |->
      (yaw_deg_o >= 17'd23040) && (yaw_deg_o <= 17'd46080))
  `BRG_ASSERT(a_third_range,
    out_valid_o && (quadrant_o == brg_pkg::QuadThird) |->
      (yaw_deg_o >= 17'd46080) && (yaw_deg_o <= 17'd69120))
  `BRG_ASSERT(a_fourth_range,
    out_valid_o && (quadrant_o == brg_pkg::QuadFourth) |->
      (yaw_deg_o >= 17'd69120) && (yaw_deg_o <= 17'd92160))
  `BRG_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o)

endmodule
